FILE: design/h8_instruction_length_decoder_defines.svh
// Assertion macros for the H8 instruction length decoder checker.
// No dependencies; take in by `include where assertions are written.
`ifndef H8_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH
`define H8_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define H8_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("h8ild check failed");

// Next-cycle implication, off while reset is asserted.
`define H8_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("h8ild check failed");

// Next-cycle implication that stays live through reset.
`define H8_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("h8ild check failed");

`endif

FILE: design/h8ild_pkg.sv
// Shared types and constants for the H8 instruction length decoder.
// No dependencies.
package h8ild_pkg;

    localparam int WINDOW_BYTES = 7;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);

    typedef logic [WINDOW_BYTES-1:0][7:0] t_window;

    typedef enum logic [2:0] {
        FLOW_NONE   = 3'd0,
        FLOW_COND   = 3'd1,
        FLOW_JUMP   = 3'd2,
        FLOW_CALL   = 3'd3,
        FLOW_RET    = 3'd4,
        FLOW_REGIND = 3'd5
    } t_flow_kind;

    typedef enum logic [1:0] {
        MODE_DIRECT    = 2'd0,
        MODE_INDIRECT  = 2'd1,
        MODE_ABSOLUTE  = 2'd2,
        MODE_IMMEDIATE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0]  pc_page;
        logic [15:0] pc_offset;
        logic [7:0]  code_byte_0;
        logic [7:0]  code_byte_1;
        logic [7:0]  code_byte_2;
        logic [7:0]  code_byte_3;
        logic [7:0]  code_byte_4;
        logic [7:0]  code_byte_5;
        logic [7:0]  code_byte_6;
    } t_in_req;

    typedef struct packed {
        logic        is_valid;
        logic [2:0]  length;
        t_flow_kind  flow_kind;
        logic [7:0]  target_page;
        logic [15:0] target_offset;
        logic [3:0]  mode_nibble;
        logic [2:0]  reg_field;
        logic        word_size;
        logic [4:0]  op_group;
        logic [2:0]  op_subfield;
        logic        extended;
    } t_out_req;

    // General-operand decode handed from the operand decoder to the main decoder.
    typedef struct packed {
        logic       is_valid;
        logic [2:0] length;
        logic [3:0] mode_nibble;
        logic [2:0] reg_field;
        logic       word_size;
        logic [4:0] op_group;
        logic [2:0] op_subfield;
        logic       extended;
    } t_gen_result;

endpackage

FILE: design/h8ild_gen_decode.sv
// General-operand decoder: addressing mode, opcode byte, length and form traps.
// Depends on h8ild_pkg.
module h8ild_gen_decode (
    input  h8ild_pkg::t_window     i_window,
    output h8ild_pkg::t_gen_result o_gen
);

    logic [7:0]                      op;
    logic [3:0]                      top;
    logic [2:0]                      rf;
    logic                            ws;
    logic [h8ild_pkg::WIN_IDX_W-1:0] pos;
    logic [h8ild_pkg::WIN_IDX_W-1:0] pos_next;
    h8ild_pkg::t_mode                mode;
    logic [7:0]                      opc_first;
    logic [7:0]                      opc;
    logic                            ext;
    logic [4:0]                      grp;
    logic [2:0]                      sub;
    logic [2:0]                      tail;

    function automatic logic ctl_reg_allowed(input logic word, input logic [2:0] r);
        logic ok;
        if (word) begin
            ok = (r == 3'd0) || (r == 3'd3) || (r == 3'd4) || (r == 3'd5);
        end else begin
            ok = (r == 3'd1) || (r == 3'd3) || (r == 3'd4) || (r == 3'd5) || (r == 3'd7);
        end
        return ok;
    endfunction

    function automatic logic form_allowed(
        input logic [4:0]       g,
        input logic [2:0]       s,
        input logic             e,
        input h8ild_pkg::t_mode m,
        input logic             word
    );
        logic ok;
        unique case (g)
            5'd0: ok = ((m == h8ild_pkg::MODE_INDIRECT) || (m == h8ild_pkg::MODE_ABSOLUTE))
                       && s[2];
            5'd1: ok = (s[1] == 1'b0);
            5'd2: begin
                if (s >= 3'd3 && s <= 3'd6) begin
                    ok = (m != h8ild_pkg::MODE_IMMEDIATE);
                end else if (s <= 3'd2) begin
                    ok = (m == h8ild_pkg::MODE_DIRECT) && !word;
                end else begin
                    ok = 1'b0;
                end
            end
            5'd3:         ok = (m != h8ild_pkg::MODE_IMMEDIATE) && (s != 3'd7);
            5'd9, 5'd11:  ok = (m != h8ild_pkg::MODE_IMMEDIATE) || ctl_reg_allowed(word, s);
            5'd13:        ok = 1'b0;
            5'd15:        ok = (m != h8ild_pkg::MODE_IMMEDIATE);
            5'd16:        ok = !e;
            5'd17:        ok = ctl_reg_allowed(word, s);
            5'd18: begin
                if (e) begin
                    ok = 1'b0;
                end else if (m == h8ild_pkg::MODE_DIRECT) begin
                    ok = word;
                end else begin
                    ok = 1'b1;
                end
            end
            5'd19: ok = (m != h8ild_pkg::MODE_IMMEDIATE) && ctl_reg_allowed(word, s);
            default: ok = (g >= 5'd24) ? (m != h8ild_pkg::MODE_IMMEDIATE) : 1'b1;
        endcase
        return ok;
    endfunction

    assign op  = i_window[0];
    assign top = op[7:4];
    assign rf  = op[2:0];
    assign ws  = op[3];

    // Locate the opcode byte behind the addressing-mode extension bytes.
    always_comb begin
        priority if (top == 4'he) begin
            pos  = 3'd2;
            mode = h8ild_pkg::MODE_INDIRECT;
        end else if (top == 4'hf) begin
            pos  = 3'd3;
            mode = h8ild_pkg::MODE_INDIRECT;
        end else if (top == 4'h0 && rf == 3'd5) begin
            pos  = 3'd2;
            mode = h8ild_pkg::MODE_ABSOLUTE;
        end else if (top == 4'h0 && rf == 3'd4) begin
            pos  = ws ? 3'd3 : 3'd2;
            mode = h8ild_pkg::MODE_IMMEDIATE;
        end else if (top == 4'h1 && rf == 3'd5) begin
            pos  = 3'd3;
            mode = h8ild_pkg::MODE_ABSOLUTE;
        end else if (top == 4'hb || top == 4'hc || top == 4'hd) begin
            pos  = 3'd1;
            mode = h8ild_pkg::MODE_INDIRECT;
        end else begin
            pos  = 3'd1;
            mode = h8ild_pkg::MODE_DIRECT;
        end
    end

    assign pos_next  = pos + 3'd1;
    assign opc_first = i_window[pos];
    assign ext       = (opc_first == 8'h00);
    assign opc       = ext ? i_window[pos_next] : opc_first;
    assign grp       = opc[7:3];
    assign sub       = opc[2:0];

    // Immediate tail: subfields 4 and 6 take one byte, 5 and 7 take two.
    assign tail = ((grp == 5'd0) && sub[2] &&
                   ((mode == h8ild_pkg::MODE_INDIRECT) || (mode == h8ild_pkg::MODE_ABSOLUTE)))
                  ? (sub[0] ? 3'd2 : 3'd1) : 3'd0;

    assign o_gen.is_valid    = form_allowed(grp, sub, ext, mode, ws);
    assign o_gen.length      = pos_next + {2'b00, ext} + tail;
    assign o_gen.mode_nibble = top;
    assign o_gen.reg_field   = rf;
    assign o_gen.word_size   = ws;
    assign o_gen.op_group    = grp;
    assign o_gen.op_subfield = sub;
    assign o_gen.extended    = ext;

endmodule

FILE: design/h8ild_decode.sv
// First-byte decoder: length, flow kind and branch target for one window.
// Depends on h8ild_pkg and h8ild_gen_decode.
module h8ild_decode (
    input  h8ild_pkg::t_in_req  i_req,
    output h8ild_pkg::t_out_req o_res
);

    h8ild_pkg::t_window     win;
    h8ild_pkg::t_gen_result gen;
    logic [7:0]             op;
    logic [7:0]             b1;
    logic [7:0]             b2;
    logic [7:0]             b3;
    logic [15:0]            rel8_2;
    logic [15:0]            rel8_3;
    logic [15:0]            rel16_3;
    logic                   valid;
    logic [2:0]             len;
    h8ild_pkg::t_flow_kind  kind;
    logic [7:0]             tpage;
    logic [15:0]            toff;
    logic                   use_gen;

    always_comb begin
        win    = '0;
        win[0] = i_req.code_byte_0;
        win[1] = i_req.code_byte_1;
        win[2] = i_req.code_byte_2;
        win[3] = i_req.code_byte_3;
        win[4] = i_req.code_byte_4;
        win[5] = i_req.code_byte_5;
        win[6] = i_req.code_byte_6;
    end

    h8ild_gen_decode u_gen (
        .i_window (win),
        .o_gen    (gen)
    );

    assign op = win[0];
    assign b1 = win[1];
    assign b2 = win[2];
    assign b3 = win[3];

    // Page-relative targets wrap at 16 bits.
    assign rel8_2  = i_req.pc_offset + 16'd2 + {{8{b1[7]}}, b1};
    assign rel8_3  = i_req.pc_offset + 16'd3 + {{8{b2[7]}}, b2};
    assign rel16_3 = i_req.pc_offset + 16'd3 + {b1, b2};

    always_comb begin
        valid   = 1'b0;
        len     = 3'd1;
        kind    = h8ild_pkg::FLOW_NONE;
        tpage   = 8'h00;
        toff    = 16'h0000;
        use_gen = 1'b0;
        priority if (op == 8'h00 || op == 8'h1a) begin
            valid = 1'b1;
        end else if (op == 8'h02 || op == 8'h12) begin
            len   = 3'd2;
            valid = 1'b1;
        end else if (op == 8'h01 || op == 8'h06 || op == 8'h07) begin
            if (b1[7:3] == 5'h17) begin
                len   = 3'd3;
                kind  = h8ild_pkg::FLOW_COND;
                tpage = i_req.pc_page;
                toff  = rel8_3;
                valid = 1'b1;
            end else begin
                len  = 3'd2;
                kind = h8ild_pkg::FLOW_REGIND;
            end
        end else if (op == 8'h11) begin
            len = 3'd2;
            if (b1 == 8'h19) begin
                kind  = h8ild_pkg::FLOW_RET;
                valid = 1'b1;
            end else begin
                kind  = h8ild_pkg::FLOW_REGIND;
                valid = (b1[7:3] == 5'h19) || (b1[7:3] == 5'h1a) || (b1[7:3] == 5'h1b);
            end
        end else if (op == 8'h10 || op == 8'h18) begin
            len   = 3'd3;
            kind  = (op == 8'h10) ? h8ild_pkg::FLOW_JUMP : h8ild_pkg::FLOW_CALL;
            tpage = i_req.pc_page;
            toff  = {b1, b2};
            valid = 1'b1;
        end else if (op == 8'h03 || op == 8'h13) begin
            len   = 3'd4;
            kind  = (op == 8'h03) ? h8ild_pkg::FLOW_CALL : h8ild_pkg::FLOW_JUMP;
            tpage = b1;
            toff  = {b2, b3};
            valid = 1'b1;
        end else if (op == 8'h08) begin
            len   = 3'd2;
            valid = (b1[7:4] == 4'h1);
        end else if (op == 8'h0a || op == 8'h19) begin
            kind  = h8ild_pkg::FLOW_RET;
            valid = 1'b1;
        end else if (op == 8'h0e) begin
            len   = 3'd2;
            kind  = h8ild_pkg::FLOW_CALL;
            tpage = i_req.pc_page;
            toff  = rel8_2;
            valid = 1'b1;
        end else if (op == 8'h1e) begin
            len   = 3'd3;
            kind  = h8ild_pkg::FLOW_CALL;
            tpage = i_req.pc_page;
            toff  = rel16_3;
            valid = 1'b1;
        end else if (op == 8'h14 || op == 8'h1c) begin
            len   = 3'd2;
            kind  = h8ild_pkg::FLOW_RET;
            valid = (op == 8'h14);
        end else if (op >= 8'h20 && op <= 8'h3f) begin
            len   = op[4] ? 3'd3 : 3'd2;
            toff  = op[4] ? rel16_3 : rel8_2;
            kind  = h8ild_pkg::FLOW_COND;
            tpage = i_req.pc_page;
            valid = 1'b1;
        end else if (op >= 8'h40 && op <= 8'h4f) begin
            len   = op[3] ? 3'd3 : 3'd2;
            valid = 1'b1;
        end else if (op >= 8'h50 && op <= 8'h57) begin
            len   = 3'd2;
            valid = 1'b1;
        end else if (op >= 8'h58 && op <= 8'h5f) begin
            len   = 3'd3;
            valid = 1'b1;
        end else if (op >= 8'h60 && op <= 8'h9f) begin
            len   = 3'd2;
            valid = 1'b1;
        end else if (op == 8'h04 || op == 8'h05 || op == 8'h0c || op == 8'h0d ||
                     op == 8'h15 || op == 8'h1d || op >= 8'ha0) begin
            use_gen = 1'b1;
            len     = gen.length;
            valid   = gen.is_valid;
        end else begin
            // unassigned first byte: everything stays zero
            len = 3'd0;
        end
    end

    assign o_res.is_valid      = valid;
    assign o_res.length        = valid ? len : 3'd0;
    assign o_res.flow_kind     = kind;
    assign o_res.target_page   = tpage;
    assign o_res.target_offset = toff;
    assign o_res.mode_nibble   = use_gen ? gen.mode_nibble : 4'h0;
    assign o_res.reg_field     = use_gen ? gen.reg_field   : 3'd0;
    assign o_res.word_size     = use_gen ? gen.word_size   : 1'b0;
    assign o_res.op_group      = use_gen ? gen.op_group    : 5'd0;
    assign o_res.op_subfield   = use_gen ? gen.op_subfield : 3'd0;
    assign o_res.extended      = use_gen ? gen.extended    : 1'b0;

endmodule

FILE: design/h8_instruction_length_decoder.sv
// H8/532 instruction length pre-decoder, top level.
// Throughput: one request per cycle; the input register keeps taking requests
// while a finished result waits, and stalls only when both registers are full.
// Reset (i_rst_n, synchronous, active low) empties both registers.
// Depends on h8ild_pkg and h8ild_decode.
module h8_instruction_length_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  h8ild_pkg::t_in_req  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output h8ild_pkg::t_out_req o_out_data
);

    logic                r_in_valid;
    logic                n_in_valid;
    h8ild_pkg::t_in_req  r_in_data;
    logic                r_out_valid;
    logic                n_out_valid;
    h8ild_pkg::t_out_req r_out_data;
    h8ild_pkg::t_out_req dec_res;
    logic                advance;
    logic                take_in;

    h8ild_decode u_decode (
        .i_req (r_in_data),
        .o_res (dec_res)
    );

    // Advance into the result register when it is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid  = o_in_stall ? r_in_valid : i_in_valid;
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_data <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out_data <= dec_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: design/h8ild_checker.sv
// Port-level checks for the H8 instruction length decoder, bound to the top.
// Depends on h8ild_pkg and h8_instruction_length_decoder_defines.svh.
`include "h8_instruction_length_decoder_defines.svh"

module h8ild_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input h8ild_pkg::t_in_req  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input h8ild_pkg::t_out_req o_out_data
);

    logic out_blocked;
    logic in_blocked;
    logic len_ok;

    // Hold: a request is only refused when a result is waiting on a stalled output.
    assign out_blocked = o_out_valid && i_out_stall;
    assign in_blocked  = i_in_valid && o_in_stall;
    assign len_ok      = o_out_data.is_valid == (o_out_data.length != 3'd0);

    `H8_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_blocked, o_out_valid && $stable(o_out_data))
    `H8_ASSERT_IMPLIES(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_blocked)
    `H8_ASSERT_IMPLIES(a_len_valid, i_clk, i_rst_n, o_out_valid, len_ok)
    `H8_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_blocked, i_in_valid && $stable(i_in_data))
    `H8_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind h8_instruction_length_decoder h8ild_checker u_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for h8_instruction_length_decoder: a directed table of code windows, then shaped
// random windows, each checked against a pinned result or a behavioral decoder written here.
// Depends on h8ild_pkg and the design sources.
module testbench;
    import h8ild_pkg::*;

    // First-byte opcodes
    localparam logic [7:0] OP_NOP        = 8'h00;
    localparam logic [7:0] OP_EXT_PREFIX = 8'h00;
    localparam logic [7:0] OP_SCB_F      = 8'h01;
    localparam logic [7:0] OP_LDM        = 8'h02;
    localparam logic [7:0] OP_PJSR       = 8'h03;
    localparam logic [7:0] OP_SCB_NE     = 8'h06;
    localparam logic [7:0] OP_SCB_EQ     = 8'h07;
    localparam logic [7:0] OP_TRAPA      = 8'h08;
    localparam logic [7:0] OP_RTE        = 8'h0a;
    localparam logic [7:0] OP_BSR_D8     = 8'h0e;
    localparam logic [7:0] OP_JMP_ABS    = 8'h10;
    localparam logic [7:0] OP_REG_IND    = 8'h11;
    localparam logic [7:0] OP_STM        = 8'h12;
    localparam logic [7:0] OP_PJMP       = 8'h13;
    localparam logic [7:0] OP_RTD        = 8'h14;
    localparam logic [7:0] OP_JSR_ABS    = 8'h18;
    localparam logic [7:0] OP_RTS        = 8'h19;
    localparam logic [7:0] OP_SLEEP      = 8'h1a;
    localparam logic [7:0] OP_PRTD       = 8'h1c;
    localparam logic [7:0] OP_BSR_D16    = 8'h1e;
    localparam logic [7:0] BCC_LO        = 8'h20;
    localparam logic [7:0] MOVS_LO       = 8'h60;
    localparam logic [7:0] MOVS_HI       = 8'h9f;
    localparam logic [7:0] GEN_LO        = 8'ha0;
    localparam logic [2:0] BCC_TOP       = 3'b001;
    localparam logic [3:0] CMP_TOP       = 4'h4;
    localparam logic [4:0] MOVE_TOP      = 5'b01010;
    localparam logic [4:0] MOVI_TOP      = 5'b01011;

    // Second-byte tags
    localparam logic [4:0] SCB_TAG   = 5'h17;
    localparam logic [7:0] PRTS_CODE = 8'h19;
    localparam logic [4:0] IND_LO    = 5'h19;
    localparam logic [4:0] IND_HI    = 5'h1b;
    localparam logic [3:0] TRAPA_TAG = 4'h1;

    // General-operand addressing nibbles and register slots
    localparam logic [3:0] NIB_LOW     = 4'h0;
    localparam logic [3:0] NIB_ABS16   = 4'h1;
    localparam logic [3:0] NIB_REG     = 4'ha;
    localparam logic [3:0] NIB_PREDEC  = 4'hb;
    localparam logic [3:0] NIB_POSTINC = 4'hc;
    localparam logic [3:0] NIB_IND     = 4'hd;
    localparam logic [3:0] NIB_DISP8   = 4'he;
    localparam logic [3:0] NIB_DISP16  = 4'hf;
    localparam logic [2:0] RF_IMM      = 3'd4;
    localparam logic [2:0] RF_ABS      = 3'd5;

    // Opcode groups of the general form
    localparam logic [4:0] GRP_IMM_TAIL = 5'd0;
    localparam logic [4:0] GRP_QUICK    = 5'd1;
    localparam logic [4:0] GRP_UNARY    = 5'd2;
    localparam logic [4:0] GRP_SHIFT    = 5'd3;
    localparam logic [4:0] GRP_CTL_A    = 5'd9;
    localparam logic [4:0] GRP_CTL_B    = 5'd11;
    localparam logic [4:0] GRP_TRAP     = 5'd13;
    localparam logic [4:0] GRP_MEM_ONLY = 5'd15;
    localparam logic [4:0] GRP_STORE    = 5'd16;
    localparam logic [4:0] GRP_LDC      = 5'd17;
    localparam logic [4:0] GRP_XFER     = 5'd18;
    localparam logic [4:0] GRP_STC      = 5'd19;
    localparam logic [4:0] GRP_HIGH     = 5'd24;

    // Control registers
    localparam logic [2:0] CR_SR  = 3'd0;
    localparam logic [2:0] CR_CCR = 3'd1;
    localparam logic [2:0] CR_BR  = 3'd3;
    localparam logic [2:0] CR_EP  = 3'd4;
    localparam logic [2:0] CR_DP  = 3'd5;
    localparam logic [2:0] CR_TP  = 3'd7;

    localparam int       DIRECTED_ROWS   = 25;
    localparam int       RANDOM_REQUESTS = 450;
    localparam int       HOLD_OFF_AT     = 100;
    localparam int       PAUSE_AT        = 250;
    localparam int       HOLD_OFF_CYCLES = 40;
    localparam int       DRAIN_CYCLES    = 10;
    localparam t_out_req NO_PIN          = '0;

    typedef struct packed {
        t_in_req  stim;
        logic     pinned;
        t_out_req want;
    } t_directed_row;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_data;

    t_out_req pending_decodes [$];
    t_out_req expected_decode;
    int       mismatches      = 0;
    bit       hold_off_request = 1'b0;

    h8_instruction_length_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic ctl_reg_ok(logic word, logic [2:0] r);
        if (word) return r == CR_SR || r == CR_BR || r == CR_EP || r == CR_DP;
        return r == CR_CCR || r == CR_BR || r == CR_EP || r == CR_DP || r == CR_TP;
    endfunction

    function automatic t_out_req decode_window(t_in_req req);
        logic [7:0]  wb [0:7];
        logic [7:0]  op, b1, opc;
        logic [15:0] w1, w2;
        logic [2:0]  sub, rf;
        logic [4:0]  grp;
        logic        ok, ws, ext;
        t_mode       mode;
        t_out_req    res;
        int          n;
        wb[0] = req.code_byte_0;
        wb[1] = req.code_byte_1;
        wb[2] = req.code_byte_2;
        wb[3] = req.code_byte_3;
        wb[4] = req.code_byte_4;
        wb[5] = req.code_byte_5;
        wb[6] = req.code_byte_6;
        wb[7] = 8'h00;
        op = wb[0];
        b1 = wb[1];
        w1 = {wb[1], wb[2]};
        w2 = {wb[2], wb[3]};
        res = '0;
        n = 1;
        ok = 1'b0;
        if (op == OP_NOP || op == OP_SLEEP || op == OP_LDM || op == OP_STM) begin
            if (op == OP_LDM || op == OP_STM) n = 2;
            ok = 1'b1;
        end else if (op == OP_SCB_F || op == OP_SCB_NE || op == OP_SCB_EQ) begin
            if (b1[7:3] == SCB_TAG) begin
                n = 3;
                res.flow_kind = FLOW_COND;
                res.target_page = req.pc_page;
                res.target_offset = req.pc_offset + 16'd3 + {{8{wb[2][7]}}, wb[2]};
                ok = 1'b1;
            end else begin
                n = 2;
                res.flow_kind = FLOW_REGIND;
            end
        end else if (op == OP_REG_IND) begin
            n = 2;
            if (b1 == PRTS_CODE) begin
                res.flow_kind = FLOW_RET;
                ok = 1'b1;
            end else begin
                res.flow_kind = FLOW_REGIND;
                ok = b1[7:3] >= IND_LO && b1[7:3] <= IND_HI;
            end
        end else if (op == OP_JMP_ABS || op == OP_JSR_ABS) begin
            n = 3;
            res.flow_kind = (op == OP_JMP_ABS) ? FLOW_JUMP : FLOW_CALL;
            res.target_page = req.pc_page;
            res.target_offset = w1;
            ok = 1'b1;
        end else if (op == OP_PJSR || op == OP_PJMP) begin
            n = 4;
            res.flow_kind = (op == OP_PJSR) ? FLOW_CALL : FLOW_JUMP;
            res.target_page = b1;
            res.target_offset = w2;
            ok = 1'b1;
        end else if (op == OP_TRAPA) begin
            n = 2;
            ok = b1[7:4] == TRAPA_TAG;
        end else if (op == OP_RTE || op == OP_RTS) begin
            res.flow_kind = FLOW_RET;
            ok = 1'b1;
        end else if (op == OP_BSR_D8) begin
            n = 2;
            res.flow_kind = FLOW_CALL;
            res.target_page = req.pc_page;
            res.target_offset = req.pc_offset + 16'd2 + {{8{b1[7]}}, b1};
            ok = 1'b1;
        end else if (op == OP_BSR_D16) begin
            n = 3;
            res.flow_kind = FLOW_CALL;
            res.target_page = req.pc_page;
            res.target_offset = req.pc_offset + 16'd3 + w1;
            ok = 1'b1;
        end else if (op == OP_RTD || op == OP_PRTD) begin
            n = 2;
            res.flow_kind = FLOW_RET;
            ok = (op == OP_RTD);
        end else if (op[7:5] == BCC_TOP) begin
            if (op[4]) begin
                n = 3;
                res.target_offset = req.pc_offset + 16'd3 + w1;
            end else begin
                n = 2;
                res.target_offset = req.pc_offset + 16'd2 + {{8{b1[7]}}, b1};
            end
            res.flow_kind = FLOW_COND;
            res.target_page = req.pc_page;
            ok = 1'b1;
        end else if (op[7:4] == CMP_TOP) begin
            n = op[3] ? 3 : 2;
            ok = 1'b1;
        end else if (op[7:3] == MOVE_TOP) begin
            n = 2;
            ok = 1'b1;
        end else if (op[7:3] == MOVI_TOP) begin
            n = 3;
            ok = 1'b1;
        end else if (op >= MOVS_LO && op <= MOVS_HI) begin
            n = 2;
            ok = 1'b1;
        end else if ((op[7:4] == NIB_LOW && (op[2:0] == RF_IMM || op[2:0] == RF_ABS)) ||
                     (op[7:4] == NIB_ABS16 && op[2:0] == RF_ABS) || op >= GEN_LO) begin
            rf = op[2:0];
            ws = op[3];
            ext = 1'b0;
            mode = MODE_DIRECT;
            res.mode_nibble = op[7:4];
            res.reg_field = rf;
            res.word_size = ws;
            if (op[7:4] == NIB_DISP8) begin
                n += 1;
                mode = MODE_INDIRECT;
            end else if (op[7:4] == NIB_DISP16) begin
                n += 2;
                mode = MODE_INDIRECT;
            end else if (op[7:4] == NIB_LOW && rf == RF_ABS) begin
                n += 1;
                mode = MODE_ABSOLUTE;
            end else if (op[7:4] == NIB_LOW && rf == RF_IMM) begin
                n += ws ? 2 : 1;
                mode = MODE_IMMEDIATE;
            end else if (op[7:4] == NIB_ABS16 && rf == RF_ABS) begin
                n += 2;
                mode = MODE_ABSOLUTE;
            end else if (op[7:4] == NIB_PREDEC || op[7:4] == NIB_POSTINC ||
                         op[7:4] == NIB_IND) begin
                mode = MODE_INDIRECT;
            end
            opc = wb[n];
            n += 1;
            if (opc == OP_EXT_PREFIX) begin
                opc = wb[n];
                n += 1;
                ext = 1'b1;
            end
            sub = opc[2:0];
            grp = opc[7:3];
            // Immediate tail follows the subfield, not the operand size
            if (grp == GRP_IMM_TAIL && (mode == MODE_INDIRECT || mode == MODE_ABSOLUTE) &&
                sub[2])
                n += sub[0] ? 2 : 1;
            case (grp)
                GRP_IMM_TAIL: ok = (mode == MODE_INDIRECT || mode == MODE_ABSOLUTE) &&
                                   sub >= 3'd4;
                GRP_QUICK:    ok = !sub[1];
                GRP_UNARY: begin
                    if (sub >= 3'd3 && sub <= 3'd6) ok = mode != MODE_IMMEDIATE;
                    else if (sub <= 3'd2) ok = mode == MODE_DIRECT && !ws;
                    else ok = 1'b0;
                end
                GRP_SHIFT:    ok = mode != MODE_IMMEDIATE && sub != 3'd7;
                GRP_CTL_A,
                GRP_CTL_B:    ok = mode != MODE_IMMEDIATE || ctl_reg_ok(ws, sub);
                GRP_TRAP:     ok = 1'b0;
                GRP_MEM_ONLY: ok = mode != MODE_IMMEDIATE;
                GRP_STORE:    ok = !ext;
                GRP_LDC:      ok = ctl_reg_ok(ws, sub);
                GRP_XFER:     ok = ext ? 1'b0 : (mode == MODE_DIRECT ? ws : 1'b1);
                GRP_STC:      ok = mode != MODE_IMMEDIATE && ctl_reg_ok(ws, sub);
                default:      ok = (grp >= GRP_HIGH) ? (mode != MODE_IMMEDIATE) : 1'b1;
            endcase
            res.op_group = grp;
            res.op_subfield = sub;
            res.extended = ext;
        end else begin
            n = 0;
        end
        res.is_valid = ok;
        res.length = ok ? n[2:0] : 3'd0;
        return res;
    endfunction

    function automatic t_out_req pinned(logic valid, logic [2:0] len, t_flow_kind kind);
        t_out_req res;
        res = '0;
        res.is_valid = valid;
        res.length = len;
        res.flow_kind = kind;
        return res;
    endfunction

    // Rows with a typed-in result carry pinned = 1; the rest go through the predictor.
    function automatic t_directed_row directed_row(int idx);
        t_directed_row row;
        case (idx)
            0:  row = {8'h00, 16'h0000, 56'h00_00_00_00_00_00_00, 1'b1,
                       pinned(1'b1, 3'd1, FLOW_NONE)};
            1:  row = {8'hff, 16'hffff, 56'h09_ff_ff_ff_ff_ff_ff, 1'b1,
                       pinned(1'b0, 3'd0, FLOW_NONE)};
            2:  row = {8'h12, 16'h3456, 56'h1c_ff_ff_ff_ff_ff_ff, 1'b1,
                       pinned(1'b0, 3'd0, FLOW_RET)};
            3:  row = {8'h00, 16'h8000, 56'h14_7f_00_00_00_00_00, 1'b1,
                       pinned(1'b1, 3'd2, FLOW_RET)};
            4:  row = {8'h55, 16'h0100, 56'h01_00_b8_00_00_00_00, 1'b1,
                       pinned(1'b0, 3'd0, FLOW_REGIND)};
            5:  row = {8'hff, 16'h0000, 56'h06_b8_80_00_00_00_00, 1'b0, NO_PIN};
            6:  row = {8'h00, 16'hffff, 56'h07_bf_7f_ff_ff_ff_ff, 1'b0, NO_PIN};
            7:  row = {8'haa, 16'h1234, 56'h11_19_00_00_00_00_00, 1'b1,
                       pinned(1'b1, 3'd2, FLOW_RET)};
            8:  row = {8'h01, 16'h0002, 56'h11_c8_00_00_00_00_00, 1'b0, NO_PIN};
            9:  row = {8'h02, 16'h0003, 56'h11_00_ff_ff_ff_ff_ff, 1'b1,
                       pinned(1'b0, 3'd0, FLOW_REGIND)};
            10: row = {8'hff, 16'h4000, 56'h10_ff_ff_00_00_00_00, 1'b0, NO_PIN};
            11: row = {8'h00, 16'h0000, 56'h13_ff_ff_ff_00_00_00, 1'b0, NO_PIN};
            12: row = {8'hff, 16'hffff, 56'h03_00_00_00_ff_ff_ff, 1'b0, NO_PIN};
            13: row = {8'h33, 16'h7777, 56'h08_1f_00_00_00_00_00, 1'b1,
                       pinned(1'b1, 3'd2, FLOW_NONE)};
            14: row = {8'h33, 16'h7777, 56'h08_20_00_00_00_00_00, 1'b1,
                       pinned(1'b0, 3'd0, FLOW_NONE)};
            15: row = {8'h80, 16'h0001, 56'h0e_80_00_00_00_00_00, 1'b0, NO_PIN};
            16: row = {8'h7f, 16'hffff, 56'h1e_7f_ff_00_00_00_00, 1'b0, NO_PIN};
            17: row = {8'h01, 16'h0000, 56'h3f_80_00_00_00_00_00, 1'b0, NO_PIN};
            18: row = {8'h00, 16'h0010, 56'h4f_12_34_00_00_00_00, 1'b0, NO_PIN};
            19: row = {8'hc3, 16'h5a5a, 56'h19_00_00_00_00_00_00, 1'b1,
                       pinned(1'b1, 3'd1, FLOW_RET)};
            20: row = {8'h10, 16'hfffe, 56'hf7_d1_d2_00_00_07_ee, 1'b0, NO_PIN};
            21: row = {8'h00, 16'h0000, 56'h04_55_04_00_00_00_00, 1'b0, NO_PIN};
            22: row = {8'h00, 16'h0000, 56'h0c_12_34_98_00_00_00, 1'b0, NO_PIN};
            23: row = {8'h00, 16'h0000, 56'h15_12_34_68_00_00_00, 1'b0, NO_PIN};
            24: row = {8'h00, 16'h0000, 56'ha8_90_00_00_00_00_00, 1'b0, NO_PIN};
            default: row = '0;
        endcase
        return row;
    endfunction

    task automatic send_request(input t_in_req req, input logic pin, input t_out_req want);
        int gap;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gap = 0;
            11, 12, 13, 14, 15, 16, 17:       gap = $urandom_range(1, 3);
            default:                          gap = $urandom_range(6, 20);
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_decodes.push_back(pin ? want : decode_window(req));
    endtask

    // Drop valid and wait for every outstanding request to come back.
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                mismatches++;
            end else begin
                expected_decode = pending_decodes.pop_front();
                check_field("is_valid", expected_decode.is_valid, o_out_data.is_valid);
                check_field("length", expected_decode.length, o_out_data.length);
                check_field("flow_kind", expected_decode.flow_kind, o_out_data.flow_kind);
                check_field("target_page", expected_decode.target_page,
                            o_out_data.target_page);
                check_field("target_offset", expected_decode.target_offset,
                            o_out_data.target_offset);
                check_field("mode_nibble", expected_decode.mode_nibble,
                            o_out_data.mode_nibble);
                check_field("reg_field", expected_decode.reg_field, o_out_data.reg_field);
                check_field("word_size", expected_decode.word_size, o_out_data.word_size);
                check_field("op_group", expected_decode.op_group, o_out_data.op_group);
                check_field("op_subfield", expected_decode.op_subfield,
                            o_out_data.op_subfield);
                check_field("extended", expected_decode.extended, o_out_data.extended);
            end
        end
    end

    initial begin : result_stall
        int run;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                // Hold off long enough for both registers to fill and the input to stall
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_request = 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                        i_out_stall <= 1'b0;
                        run = $urandom_range(1, 8);
                    end
                    12, 13, 14, 15, 16, 17: begin
                        i_out_stall <= 1'b1;
                        run = $urandom_range(1, 3);
                    end
                    18: begin
                        i_out_stall <= 1'b1;
                        run = $urandom_range(8, 25);
                    end
                    default: begin
                        i_out_stall <= 1'b0;
                        run = $urandom_range(20, 60);
                    end
                endcase
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_directed_row row;
        t_in_req       req;
        logic [7:0]    win [0:6];
        logic [3:0]    nib;
        logic [2:0]    rf;
        logic          ws;
        int            k, j, opos;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_row(k);
            send_request(row.stim, row.pinned, row.want);
        end
        drain_requests();

        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            for (j = 0; j < 7; j++) win[j] = 8'($urandom);
            req.pc_page = 8'($urandom);
            req.pc_offset = 16'($urandom);
            case ($urandom_range(0, 7))
                0: req.pc_offset = 16'h0000;
                1: req.pc_offset = 16'hffff;
                2: req.pc_page = 8'h00;
                3: req.pc_page = 8'hff;
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0, 1: ;
                2, 3: win[0] = 8'($urandom_range(0, BCC_LO - 1));
                4: begin
                    case ($urandom_range(0, 2))
                        0: win[0] = OP_SCB_F;
                        1: win[0] = OP_SCB_NE;
                        default: win[0] = OP_SCB_EQ;
                    endcase
                    if ($urandom_range(0, 3) != 0) win[1][7:3] = SCB_TAG;
                end
                5: begin
                    win[0] = OP_REG_IND;
                    case ($urandom_range(0, 3))
                        0: win[1] = PRTS_CODE;
                        1, 2: win[1][7:3] = 5'($urandom_range(IND_LO, IND_HI));
                        default: ;
                    endcase
                end
                6: begin
                    win[0] = OP_TRAPA;
                    if ($urandom_range(0, 2) != 0) win[1][7:4] = TRAPA_TAG;
                end
                7, 8: win[0] = 8'($urandom_range(BCC_LO, MOVS_HI));
                default: begin
                    // General operand: address mode, optional prefix, then the opcode byte
                    if ($urandom_range(0, 3) == 0) begin
                        nib = $urandom_range(0, 1) ? NIB_LOW : NIB_ABS16;
                        rf = (nib == NIB_LOW && $urandom_range(0, 1)) ? RF_IMM : RF_ABS;
                        win[0] = {nib, 1'($urandom), rf};
                    end else begin
                        win[0] = {4'($urandom_range(NIB_REG, NIB_DISP16)), 4'($urandom)};
                    end
                    nib = win[0][7:4];
                    rf = win[0][2:0];
                    ws = win[0][3];
                    opos = 1;
                    if (nib == NIB_DISP8 || (nib == NIB_LOW && rf == RF_ABS)) opos = 2;
                    else if (nib == NIB_DISP16 || nib == NIB_ABS16) opos = 3;
                    else if (nib == NIB_LOW) opos = ws ? 3 : 2;
                    if ($urandom_range(0, 3) == 0) begin
                        win[opos] = OP_EXT_PREFIX;
                        opos++;
                    end
                    case ($urandom_range(0, 3))
                        0: win[opos] = {GRP_IMM_TAIL, 3'($urandom)};
                        1: begin
                            case ($urandom_range(0, 5))
                                0: win[opos] = {GRP_CTL_A, 3'($urandom)};
                                1: win[opos] = {GRP_CTL_B, 3'($urandom)};
                                2: win[opos] = {GRP_LDC, 3'($urandom)};
                                3: win[opos] = {GRP_STC, 3'($urandom)};
                                4: win[opos] = {GRP_XFER, 3'($urandom)};
                                default: win[opos] = {GRP_STORE, 3'($urandom)};
                            endcase
                        end
                        default: ;
                    endcase
                end
            endcase
            req.code_byte_0 = win[0];
            req.code_byte_1 = win[1];
            req.code_byte_2 = win[2];
            req.code_byte_3 = win[3];
            req.code_byte_4 = win[4];
            req.code_byte_5 = win[5];
            req.code_byte_6 = win[6];
            send_request(req, 1'b0, NO_PIN);
            if (k == HOLD_OFF_AT) hold_off_request = 1'b1;
            if (k == PAUSE_AT) drain_requests();
        end

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
